// ===== sv/mtp_pkg.sv =====
// Package with the shared types, constants and functions of the Mersenne Twister generator.
package mtp_pkg;

  localparam int unsigned STATE_N = 624;
  localparam int unsigned FAR_M   = 397;
  localparam int unsigned AW      = 10;

  localparam logic [AW-1:0] LAST_ADDR = AW'(STATE_N - 1);
  localparam logic [AW-1:0] FAR_ADDR  = AW'(FAR_M);
  localparam logic [AW:0]   N_WIDE    = (AW + 1)'(STATE_N);

  localparam logic [31:0] KNUTH_MUL  = 32'd1812433253;
  localparam logic [31:0] BASE_SEED  = 32'd19650218;
  localparam logic [31:0] MIX1_MUL   = 32'd1664525;
  localparam logic [31:0] MIX2_MUL   = 32'd1566083941;
  localparam logic [31:0] UPPER_MASK = 32'h8000_0000;
  localparam logic [31:0] LOWER_MASK = 32'h7FFF_FFFF;
  localparam logic [31:0] MATRIX_A   = 32'h9908_B0DF;
  localparam logic [31:0] TEMPER_B   = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C   = 32'hEFC6_0000;

  typedef enum logic [1:0] {
    ACT_SEED = 2'd0,
    ACT_KEY  = 2'd1,
    ACT_GET  = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SS_W0,
    ST_SS_MUL,
    ST_SS_WR,
    ST_P_RD,
    ST_P_MUL,
    ST_P_WR,
    ST_P_WRAP,
    ST_FINAL,
    ST_RG_RD,
    ST_RG_FAR,
    ST_RG_WR,
    ST_GET_RD,
    ST_GET_OUT
  } state_e;

  typedef enum logic [2:0] {
    WS_ZERO,
    WS_SEED,
    WS_KNUTH,
    WS_PASS1,
    WS_PASS2,
    WS_REGEN,
    WS_LAST,
    WS_UPPER
  } wsel_e;

  typedef enum logic [1:0] {
    MS_KNUTH,
    MS_PASS1,
    MS_PASS2
  } msel_e;

  typedef struct packed {
    logic          rd_en;
    logic [AW-1:0] rd_a;
    logic [AW-1:0] rd_b;
    logic          mul_en;
    msel_e         msel;
    logic          mix_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    wsel_e         wsel;
    logic          seed_load;
    logic          seed_base;
    logic          out_load;
    logic [AW-1:0] i_val;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } stat_t;

  function automatic logic [31:0] twist(input logic [31:0] hi, input logic [31:0] lo);
    logic [31:0] y;
    y = (hi & UPPER_MASK) | (lo & LOWER_MASK);
    return (y >> 1) ^ (lo[0] ? MATRIX_A : 32'd0);
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] v);
    logic [31:0] x;
    x = v ^ (v >> 11);
    x = x ^ ((x << 7) & TEMPER_B);
    x = x ^ ((x << 15) & TEMPER_C);
    x = x ^ (x >> 18);
    return x;
  endfunction

endpackage

// ===== sv/mtp_datapath.sv =====
// Datapath of the generator: state memory, key memory, multiplier and output register.
module mtp_datapath #(
  parameter int unsigned KEY_MAX = 64,
  parameter int unsigned KAW = 6
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mtp_pkg::cmd_t  cmd_i,
  output mtp_pkg::stat_t stat_o,
  input  logic           key_wr_en_i,
  input  logic [KAW-1:0] key_wr_addr_i,
  input  logic [KAW-1:0] key_rd_addr_i,
  input  logic [KAW-1:0] j_i,
  input  logic [31:0]    seed_word_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [31:0]    random_word_o
);

  logic [31:0] state_mem [mtp_pkg::STATE_N];
  logic [31:0] key_mem [KEY_MAX];
  logic [31:0] rd_a_q, rd_b_q, key_q;
  logic [31:0] prod_q, mix_q, last_q, seed_q, out_q;
  logic        out_valid_q;
  logic [31:0] wdata, mul_x, mul_c, mixed;

  always_comb begin
    mul_x = rd_a_q;
    mul_c = mtp_pkg::KNUTH_MUL;
    case (cmd_i.msel)
      mtp_pkg::MS_KNUTH: begin
        mul_x = last_q;
        mul_c = mtp_pkg::KNUTH_MUL;
      end
      mtp_pkg::MS_PASS1: mul_c = mtp_pkg::MIX1_MUL;
      mtp_pkg::MS_PASS2: mul_c = mtp_pkg::MIX2_MUL;
      default: mul_c = mtp_pkg::KNUTH_MUL;
    endcase
  end

  assign mixed = rd_b_q ^ prod_q;

  always_comb begin
    case (cmd_i.wsel)
      mtp_pkg::WS_ZERO:  wdata = 32'd0;
      mtp_pkg::WS_SEED:  wdata = seed_q;
      mtp_pkg::WS_KNUTH: wdata = prod_q + 32'(cmd_i.i_val);
      mtp_pkg::WS_PASS1: wdata = mixed + key_q + 32'(j_i);
      mtp_pkg::WS_PASS2: wdata = mixed - 32'(cmd_i.i_val);
      mtp_pkg::WS_REGEN: wdata = rd_a_q ^ mix_q;
      mtp_pkg::WS_LAST:  wdata = last_q;
      mtp_pkg::WS_UPPER: wdata = mtp_pkg::UPPER_MASK;
      default:           wdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      state_mem[cmd_i.wr_addr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rd_a_q <= state_mem[cmd_i.rd_a];
      rd_b_q <= state_mem[cmd_i.rd_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_wr_en_i) begin
      key_mem[key_wr_addr_i] <= seed_word_i;
    end
    if (cmd_i.rd_en) begin
      key_q <= key_mem[key_rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      last_q <= wdata;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_c * (mul_x ^ (mul_x >> 30));
    end
    if (cmd_i.mix_en) begin
      mix_q <= mtp_pkg::twist(rd_a_q, rd_b_q);
    end
    if (cmd_i.seed_load) begin
      seed_q <= cmd_i.seed_base ? mtp_pkg::BASE_SEED : seed_word_i;
    end
    if (cmd_i.out_load) begin
      out_q <= mtp_pkg::temper(rd_a_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.out_full = out_valid_q && out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign random_word_o   = out_q;

endmodule

// ===== sv/mtp_controller.sv =====
// Controller state machine that sequences clearing, seeding, regeneration and reads.
module mtp_controller #(
  parameter int unsigned KEY_MAX = 64,
  parameter int unsigned KAW = 6,
  parameter int unsigned KCW = 7
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     action_i,
  input  logic           last_key_i,
  output mtp_pkg::cmd_t  cmd_o,
  input  mtp_pkg::stat_t stat_i,
  output logic           key_wr_en_o,
  output logic [KAW-1:0] key_wr_addr_o,
  output logic [KAW-1:0] key_rd_addr_o,
  output logic [KAW-1:0] j_o
);

  localparam int unsigned KW = (KCW > 11) ? KCW : 11;
  localparam logic [KCW-1:0] KEY_FULL = KCW'(KEY_MAX);

  mtp_pkg::state_e state_q, state_d;
  logic [mtp_pkg::AW-1:0] i_q, i_d;
  logic [mtp_pkg::AW:0]   ridx_q, ridx_d;
  logic [KAW-1:0]         j_q, j_d;
  logic [KW-1:0]          k_q, k_d;
  logic [KCW-1:0]         cnt_q, cnt_d, size_q, size_d, cnt_new;
  logic                   arr_q, arr_d, pass_q, pass_d;
  logic                   accept, cnt_room, pass_done;
  logic [mtp_pkg::AW-1:0] i_next, i_far;
  logic [mtp_pkg::AW:0]   far_sum;
  logic [KCW-1:0]         j_inc;
  logic [KW-1:0]          rounds;

  assign accept   = in_valid_i && (state_q == mtp_pkg::ST_IDLE);
  assign cnt_room = cnt_q < KEY_FULL;
  assign cnt_new  = cnt_room ? cnt_q + KCW'(1) : cnt_q;
  assign i_next   = (i_q == mtp_pkg::LAST_ADDR) ? '0 : i_q + 1'b1;
  assign far_sum  = {1'b0, i_q} + {1'b0, mtp_pkg::FAR_ADDR};
  assign i_far    = (far_sum >= mtp_pkg::N_WIDE) ? mtp_pkg::AW'(far_sum - mtp_pkg::N_WIDE)
                                                 : far_sum[mtp_pkg::AW-1:0];
  assign j_inc    = KCW'(j_q) + KCW'(1);
  assign rounds   = (KW'(size_q) > KW'(mtp_pkg::STATE_N)) ? KW'(size_q)
                                                          : KW'(mtp_pkg::STATE_N);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtp_pkg::ST_CLEAR;
      i_q     <= '0;
      ridx_q  <= '0;
      j_q     <= '0;
      k_q     <= '0;
      cnt_q   <= '0;
      size_q  <= '0;
      arr_q   <= 1'b0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      ridx_q  <= ridx_d;
      j_q     <= j_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      size_q  <= size_d;
      arr_q   <= arr_d;
      pass_q  <= pass_d;
    end
  end

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    ridx_d  = ridx_q;
    j_d     = j_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    size_d  = size_q;
    arr_d   = arr_q;
    pass_d  = pass_q;
    pass_done = 1'b0;

    cmd_o           = '0;
    cmd_o.msel      = mtp_pkg::MS_KNUTH;
    cmd_o.wsel      = mtp_pkg::WS_ZERO;
    cmd_o.i_val     = i_q;
    cmd_o.rd_a      = i_q;
    cmd_o.rd_b      = i_q;
    cmd_o.wr_addr   = i_q;
    key_wr_en_o     = 1'b0;
    key_wr_addr_o   = cnt_q[KAW-1:0];
    key_rd_addr_o   = j_q;
    in_stall_o      = (state_q != mtp_pkg::ST_IDLE);

    case (state_q)
      mtp_pkg::ST_CLEAR: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsel  = mtp_pkg::WS_ZERO;
        if (i_q == mtp_pkg::LAST_ADDR) begin
          i_d     = '0;
          state_d = mtp_pkg::ST_IDLE;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      mtp_pkg::ST_IDLE: begin
        if (accept) begin
          case (mtp_pkg::action_e'(action_i))
            mtp_pkg::ACT_SEED: begin
              cmd_o.seed_load = 1'b1;
              arr_d   = 1'b0;
              state_d = mtp_pkg::ST_SS_W0;
            end
            mtp_pkg::ACT_KEY: begin
              key_wr_en_o = cnt_room;
              cnt_d       = cnt_new;
              if (last_key_i) begin
                size_d          = cnt_new;
                cnt_d           = '0;
                cmd_o.seed_load = 1'b1;
                cmd_o.seed_base = 1'b1;
                arr_d           = 1'b1;
                state_d         = mtp_pkg::ST_SS_W0;
              end
            end
            mtp_pkg::ACT_GET: begin
              if (ridx_q >= mtp_pkg::N_WIDE) begin
                i_d     = '0;
                state_d = mtp_pkg::ST_RG_RD;
              end else begin
                state_d = mtp_pkg::ST_GET_RD;
              end
            end
            default: state_d = mtp_pkg::ST_IDLE;
          endcase
        end
      end
      mtp_pkg::ST_SS_W0: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = '0;
        cmd_o.wsel    = mtp_pkg::WS_SEED;
        i_d           = mtp_pkg::AW'(1);
        state_d       = mtp_pkg::ST_SS_MUL;
      end
      mtp_pkg::ST_SS_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.msel   = mtp_pkg::MS_KNUTH;
        state_d      = mtp_pkg::ST_SS_WR;
      end
      mtp_pkg::ST_SS_WR: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsel  = mtp_pkg::WS_KNUTH;
        if (i_q == mtp_pkg::LAST_ADDR) begin
          ridx_d = mtp_pkg::N_WIDE;
          if (arr_q) begin
            i_d     = mtp_pkg::AW'(1);
            j_d     = '0;
            k_d     = rounds;
            pass_d  = 1'b0;
            state_d = mtp_pkg::ST_P_RD;
          end else begin
            state_d = mtp_pkg::ST_IDLE;
          end
        end else begin
          i_d     = i_q + 1'b1;
          state_d = mtp_pkg::ST_SS_MUL;
        end
      end
      mtp_pkg::ST_P_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_a  = i_q - 1'b1;
        cmd_o.rd_b  = i_q;
        state_d     = mtp_pkg::ST_P_MUL;
      end
      mtp_pkg::ST_P_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.msel   = pass_q ? mtp_pkg::MS_PASS2 : mtp_pkg::MS_PASS1;
        state_d      = mtp_pkg::ST_P_WR;
      end
      mtp_pkg::ST_P_WR: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsel  = pass_q ? mtp_pkg::WS_PASS2 : mtp_pkg::WS_PASS1;
        k_d         = k_q - 1'b1;
        if (!pass_q) begin
          j_d = (j_inc >= size_q) ? '0 : j_q + 1'b1;
        end
        if (i_q == mtp_pkg::LAST_ADDR) begin
          i_d     = mtp_pkg::AW'(1);
          state_d = mtp_pkg::ST_P_WRAP;
        end else begin
          i_d       = i_q + 1'b1;
          pass_done = (k_q == KW'(1));
          state_d   = mtp_pkg::ST_P_RD;
        end
      end
      mtp_pkg::ST_P_WRAP: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = '0;
        cmd_o.wsel    = mtp_pkg::WS_LAST;
        pass_done     = (k_q == '0);
        state_d       = mtp_pkg::ST_P_RD;
      end
      mtp_pkg::ST_FINAL: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = '0;
        cmd_o.wsel    = mtp_pkg::WS_UPPER;
        ridx_d        = mtp_pkg::N_WIDE;
        state_d       = mtp_pkg::ST_IDLE;
      end
      mtp_pkg::ST_RG_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_a  = i_q;
        cmd_o.rd_b  = i_next;
        state_d     = mtp_pkg::ST_RG_FAR;
      end
      mtp_pkg::ST_RG_FAR: begin
        cmd_o.mix_en = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_a   = i_far;
        cmd_o.rd_b   = i_next;
        state_d      = mtp_pkg::ST_RG_WR;
      end
      mtp_pkg::ST_RG_WR: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsel  = mtp_pkg::WS_REGEN;
        if (i_q == mtp_pkg::LAST_ADDR) begin
          i_d     = '0;
          ridx_d  = '0;
          state_d = mtp_pkg::ST_GET_RD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = mtp_pkg::ST_RG_RD;
        end
      end
      mtp_pkg::ST_GET_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_a  = ridx_q[mtp_pkg::AW-1:0];
        state_d     = mtp_pkg::ST_GET_OUT;
      end
      mtp_pkg::ST_GET_OUT: begin
        if (!stat_i.out_full) begin
          cmd_o.out_load = 1'b1;
          ridx_d         = ridx_q + 1'b1;
          state_d        = mtp_pkg::ST_IDLE;
        end
      end
      default: state_d = mtp_pkg::ST_IDLE;
    endcase

    if (pass_done) begin
      if (!pass_q) begin
        pass_d = 1'b1;
        k_d    = KW'(mtp_pkg::STATE_N - 1);
      end else begin
        state_d = mtp_pkg::ST_FINAL;
      end
    end
  end

  assign j_o = j_q;

endmodule

// ===== sv/mersenne_twister_prng_core.sv =====
// Top level of the MT19937 generator joining the controller and the datapath.
//
// Channel | Direction | Signals
// in      | request   | in_valid_i, in_stall_o, action_i, seed_word_i, last_key_i
// out     | result    | out_valid_o, out_stall_i, random_word_o
//
// After reset a clearing pass writes zero to all 624 state words.
// A get request reads and tempers one state word, regenerating the whole state first when it is used up.
// Single-word seeding fills the state with the Knuth recurrence; array seeding adds
// two mixing passes over the state. The state words are handled one at a time.
// A request is taken while a result waits; a get then waits until the output is free.
module mersenne_twister_prng_core #(
  parameter int unsigned KEY_MAX = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] seed_word_i,
  input  logic        last_key_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] random_word_o
);

  localparam int unsigned KAW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int unsigned KCW = $clog2(KEY_MAX + 1);

  mtp_pkg::cmd_t  cmd;
  mtp_pkg::stat_t stat;
  logic           key_wr_en;
  logic [KAW-1:0] key_wr_addr, key_rd_addr, j_val;

  mtp_controller #(
    .KEY_MAX(KEY_MAX),
    .KAW(KAW),
    .KCW(KCW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .last_key_i   (last_key_i),
    .cmd_o        (cmd),
    .stat_i       (stat),
    .key_wr_en_o  (key_wr_en),
    .key_wr_addr_o(key_wr_addr),
    .key_rd_addr_o(key_rd_addr),
    .j_o          (j_val)
  );

  mtp_datapath #(
    .KEY_MAX(KEY_MAX),
    .KAW(KAW)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .key_wr_en_i  (key_wr_en),
    .key_wr_addr_i(key_wr_addr),
    .key_rd_addr_i(key_rd_addr),
    .j_i          (j_val),
    .seed_word_i  (seed_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .random_word_o(random_word_o)
  );

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the MT19937 generator core with a built-in predictor.
module tb;

  localparam int unsigned NUM_RANDOM = 760;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned SETTLE_CYCLES = 6000;
  localparam int unsigned KEY_LIMIT = 64;

  typedef struct {
    mtp_pkg::action_e act;
    logic [31:0]      word;
    logic             last;
  } request_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = mtp_pkg::ACT_NONE;
  logic [31:0] seed_word_i = '0;
  logic        last_key_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] random_word_o;

  request_t    pending_reqs[$];
  logic [31:0] expected_words[$];

  logic [31:0] mt_words[mtp_pkg::STATE_N];
  int unsigned mt_index;
  logic [31:0] key_words[KEY_LIMIT];
  int unsigned key_fill;

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned gets_done = 0;
  int unsigned seeds_done = 0;
  int unsigned keys_done = 0;
  int unsigned results_done = 0;
  logic        in_taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_mode_left = 0;
  int unsigned stall_mode = 0;

  mersenne_twister_prng_core #(.KEY_MAX(KEY_LIMIT)) u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .seed_word_i, .last_key_i,
    .out_valid_o, .out_stall_i, .random_word_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic knuth_fill(input logic [31:0] s);
    logic [31:0] p;
    mt_words[0] = s;
    for (int unsigned i = 1; i < mtp_pkg::STATE_N; i++) begin
      p = mt_words[i-1];
      mt_words[i] = 32'd1812433253 * (p ^ (p >> 30)) + 32'(i);
    end
    mt_index = mtp_pkg::STATE_N;
  endtask

  task automatic key_schedule(input int unsigned size);
    int unsigned i;
    int unsigned j;
    int unsigned rounds;
    logic [31:0] p;
    i = 1;
    j = 0;
    rounds = (mtp_pkg::STATE_N > size) ? mtp_pkg::STATE_N : size;
    knuth_fill(32'd19650218);
    for (int unsigned k = rounds; k > 0; k--) begin
      p = mt_words[i-1];
      mt_words[i] = (mt_words[i] ^ ((p ^ (p >> 30)) * 32'd1664525)) + key_words[j] + 32'(j);
      j++;
      if (j >= size) j = 0;
      i++;
      if (i == mtp_pkg::STATE_N) begin
        mt_words[0] = mt_words[mtp_pkg::STATE_N-1];
        i = 1;
      end
    end
    for (int unsigned k = mtp_pkg::STATE_N - 1; k > 0; k--) begin
      p = mt_words[i-1];
      mt_words[i] = (mt_words[i] ^ ((p ^ (p >> 30)) * 32'd1566083941)) - 32'(i);
      i++;
      if (i == mtp_pkg::STATE_N) begin
        mt_words[0] = mt_words[mtp_pkg::STATE_N-1];
        i = 1;
      end
    end
    mt_words[0] = 32'h8000_0000;
    mt_index = mtp_pkg::STATE_N;
  endtask

  task automatic refill_state();
    logic [31:0] y;
    logic [31:0] lo;
    for (int unsigned i = 0; i < mtp_pkg::STATE_N; i++) begin
      lo = mt_words[(i + 1) % mtp_pkg::STATE_N];
      y = (mt_words[i] & 32'h8000_0000) | (lo & 32'h7FFF_FFFF);
      mt_words[i] = mt_words[(i + mtp_pkg::FAR_M) % mtp_pkg::STATE_N] ^ (y >> 1) ^
                    (lo[0] ? 32'h9908_B0DF : 32'd0);
    end
    mt_index = 0;
  endtask

  task automatic predict_request(input request_t r);
    logic [31:0] x;
    case (r.act)
      mtp_pkg::ACT_SEED: begin
        knuth_fill(r.word);
        seeds_done++;
      end
      mtp_pkg::ACT_KEY: begin
        if (key_fill < KEY_LIMIT) begin
          key_words[key_fill] = r.word;
          key_fill++;
        end
        if (r.last) begin
          key_schedule(key_fill);
          key_fill = 0;
        end
        keys_done++;
      end
      mtp_pkg::ACT_GET: begin
        if (mt_index >= mtp_pkg::STATE_N) refill_state();
        x = mt_words[mt_index];
        mt_index++;
        x = x ^ (x >> 11);
        x = x ^ ((x << 7) & 32'h9D2C_5680);
        x = x ^ ((x << 15) & 32'hEFC6_0000);
        x = x ^ (x >> 18);
        expected_words.push_back(x);
        gets_done++;
      end
      default: ;
    endcase
  endtask

  function automatic request_t make_req(mtp_pkg::action_e a, logic [31:0] w, logic l);
    request_t r;
    r.act = a;
    r.word = w;
    r.last = l;
    return r;
  endfunction

  // Requests are predicted and results checked at the rising edge.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        $error("random_word: unexpected result %h", random_word_o);
        errors++;
      end else begin
        if (random_word_o !== expected_words[0]) begin
          $error("random_word: expected %h, actual %h", expected_words[0], random_word_o);
          errors++;
        end
        void'(expected_words.pop_front());
        results_done++;
      end
    end
    if (in_taken)
      predict_request(make_req(mtp_pkg::action_e'(action_i), seed_word_i, last_key_i));
  end

  // The request driver works in bursts and the result side stalls in modes.
  always @(negedge clk_i) begin
    logic take_next;
    request_t r;
    take_next = !in_valid_i || in_taken;
    if (rst_ni && take_next) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        in_valid_i <= 1'b0;
      end else begin
        r = pending_reqs.pop_front();
        in_valid_i <= 1'b1;
        action_i <= r.act;
        seed_word_i <= r.word;
        last_key_i <= r.last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    if (stall_mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_mode_left = $urandom_range(5, 200);
    end else begin
      stall_mode_left--;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 1) == 1);
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  initial begin
    int unsigned pick;
    key_fill = 0;
    mt_index = 0;
    for (int unsigned i = 0; i < mtp_pkg::STATE_N; i++) mt_words[i] = '0;
    for (int unsigned i = 0; i < KEY_LIMIT; i++) key_words[i] = '0;

    // A get before any seeding reads the cleared state.
    repeat (3) pending_reqs.push_back(make_req(mtp_pkg::ACT_GET, $urandom, 1'b0));
    pending_reqs.push_back(make_req(mtp_pkg::ACT_NONE, $urandom, 1'b1));
    pending_reqs.push_back(make_req(mtp_pkg::ACT_GET, 32'd0, 1'b1));
    pending_reqs.push_back(make_req(mtp_pkg::ACT_SEED, 32'd0, 1'b0));
    pending_reqs.push_back(make_req(mtp_pkg::ACT_GET, 32'hFFFF_FFFF, 1'b0));
    pending_reqs.push_back(make_req(mtp_pkg::ACT_SEED, 32'hFFFF_FFFF, 1'b1));
    pending_reqs.push_back(make_req(mtp_pkg::ACT_GET, 32'd0, 1'b0));
    pending_reqs.push_back(make_req(mtp_pkg::ACT_KEY, 32'd0, 1'b0));
    pending_reqs.push_back(make_req(mtp_pkg::ACT_KEY, 32'hFFFF_FFFF, 1'b1));
    repeat (2) pending_reqs.push_back(make_req(mtp_pkg::ACT_GET, 32'd0, 1'b0));
    pending_reqs.push_back(make_req(mtp_pkg::ACT_KEY, 32'h0000_1234, 1'b1));
    pending_reqs.push_back(make_req(mtp_pkg::ACT_GET, 32'd0, 1'b0));
    // Key words collected before a single-word seed stay pending.
    pending_reqs.push_back(make_req(mtp_pkg::ACT_KEY, 32'h1234_5678, 1'b0));
    pending_reqs.push_back(make_req(mtp_pkg::ACT_SEED, 32'd5489, 1'b0));
    pending_reqs.push_back(make_req(mtp_pkg::ACT_KEY, 32'h8765_4321, 1'b1));
    pending_reqs.push_back(make_req(mtp_pkg::ACT_GET, 32'd0, 1'b0));
    // More key words than the store holds; the extra ones are dropped.
    for (int unsigned i = 0; i < KEY_LIMIT + 6; i++)
      pending_reqs.push_back(make_req(mtp_pkg::ACT_KEY, $urandom, 1'b0));
    pending_reqs.push_back(make_req(mtp_pkg::ACT_KEY, $urandom, 1'b1));
    pending_reqs.push_back(make_req(mtp_pkg::ACT_GET, 32'd0, 1'b0));

    for (int unsigned n = 0; n < NUM_RANDOM; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 82)
        pending_reqs.push_back(make_req(mtp_pkg::ACT_GET, $urandom,
                                        1'($urandom_range(0, 1))));
      else if (pick < 91)
        pending_reqs.push_back(make_req(mtp_pkg::ACT_KEY, $urandom,
                                        $urandom_range(0, 3) == 0));
      else if (pick < 95)
        pending_reqs.push_back(make_req(mtp_pkg::ACT_SEED, $urandom,
                                        1'($urandom_range(0, 1))));
      else
        pending_reqs.push_back(make_req(mtp_pkg::ACT_NONE, $urandom,
                                        1'($urandom_range(0, 1))));
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_reqs.size() == 0);
    @(posedge clk_i);
    while (in_valid_i) @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d gets, %0d single seeds and %0d key words; %0d results checked.",
             gets_done, seeds_done, keys_done, results_done);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
